// File: hw/rtl/midpoint_ellipse_rasterizer_top_macros.svh
// Assertion macros used by the checker file of the ellipse rasterizer.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH

// Assert a property and report with a fixed message.
`define MER_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mer checker: property violated");

// Assert a property and report with a caller message.
`define MER_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// File: hw/rtl/mer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mer_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 16;

  localparam int WALKX_W  = RADIUS_BITS + 1;
  localparam int WALKY_W  = RADIUS_BITS + 2;
  localparam int TX_W     = RADIUS_BITS + 2;
  localparam int SQ_W     = 2 * RADIUS_BITS;
  localparam int TXSQ_W   = 2 * RADIUS_BITS + 2;
  localparam int AAB_W    = 3 * RADIUS_BITS;
  localparam int GRAD_W   = 4 * RADIUS_BITS;
  localparam int MUL_W    = 2 * RADIUS_BITS + 4;
  localparam int DEC_W    = 2 * MUL_W;
  localparam int OUT_W    = COORD_BITS + 1;
  localparam int PT_W     = OUT_W + WALKY_W;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_AA,
    OP_MUL_BB,
    OP_MUL_AAB,
    OP_INIT,
    OP_SW_TX,
    OP_SW_BTX,
    OP_SW_YSQ,
    OP_SW_AYY,
    OP_SW_ABB,
    OP_SW_END,
    OP_STEP,
    OP_DEC
  } dp_op_e;

  typedef struct packed {
    logic busy;
    logic second;
    logic grad_lt;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/mer_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mer_ctrl import mer_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       kind_i,
  input  wire dp_status_t status_i,
  output logic            in_stall_o,
  output dp_op_e          op_o
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_MUL_AA  = 13'b0000000000010,
    S_MUL_BB  = 13'b0000000000100,
    S_MUL_AAB = 13'b0000000001000,
    S_INIT    = 13'b0000000010000,
    S_SW_TX   = 13'b0000000100000,
    S_SW_BTX  = 13'b0000001000000,
    S_SW_YSQ  = 13'b0000010000000,
    S_SW_AYY  = 13'b0000100000000,
    S_SW_ABB  = 13'b0001000000000,
    S_SW_END  = 13'b0010000000000,
    S_STEP    = 13'b0100000000000,
    S_DEC     = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == KIND_START) begin
            op_o    = OP_LOAD;
            state_d = S_MUL_AA;
          end else if (status_i.busy) begin
            // region switch needs a fresh decision value first
            state_d = (!status_i.second && !status_i.grad_lt) ? S_SW_TX : S_STEP;
          end
        end
      end
      S_MUL_AA:  begin op_o = OP_MUL_AA;  state_d = S_MUL_BB;  end
      S_MUL_BB:  begin op_o = OP_MUL_BB;  state_d = S_MUL_AAB; end
      S_MUL_AAB: begin op_o = OP_MUL_AAB; state_d = S_INIT;    end
      S_INIT:    begin op_o = OP_INIT;    state_d = S_IDLE;    end
      S_SW_TX:   begin op_o = OP_SW_TX;   state_d = S_SW_BTX;  end
      S_SW_BTX:  begin op_o = OP_SW_BTX;  state_d = S_SW_YSQ;  end
      S_SW_YSQ:  begin op_o = OP_SW_YSQ;  state_d = S_SW_AYY;  end
      S_SW_AYY:  begin op_o = OP_SW_AYY;  state_d = S_SW_ABB;  end
      S_SW_ABB:  begin op_o = OP_SW_ABB;  state_d = S_SW_END;  end
      S_SW_END:  begin op_o = OP_SW_END;  state_d = S_STEP;    end
      S_STEP: begin
        // hold until the output register can take the point
        if (status_i.out_free) begin
          op_o    = OP_STEP;
          state_d = S_DEC;
        end
      end
      S_DEC:     begin op_o = OP_DEC;     state_d = S_IDLE;    end
      default:   begin state_d = S_IDLE; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/mer_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mer_datapath import mer_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dp_op_e                        op_i,
  input  wire logic        [RADIUS_BITS-1:0] semi_axis_x_i,
  input  wire logic        [RADIUS_BITS-1:0] semi_axis_y_i,
  input  wire logic signed [COORD_BITS-1:0]  center_x_i,
  input  wire logic signed [COORD_BITS-1:0]  center_y_i,
  input  wire logic                          out_stall_i,
  output dp_status_t                         status_o,
  output logic                               out_valid_o,
  output logic signed      [OUT_W-1:0]       point_x_o,
  output logic signed      [OUT_W-1:0]       point_y_o,
  output logic                               last_point_o
);

  logic                    busy_q, second_q, out_valid_q;
  logic [RADIUS_BITS-1:0]  axis_a_q, axis_b_q;
  logic [COORD_BITS-1:0]   origin_x_q, origin_y_q;
  logic [SQ_W-1:0]         aa_q, bb_q;
  logic [WALKX_W-1:0]      walk_x_q;
  logic [WALKY_W-1:0]      walk_y_q;
  logic [GRAD_W-1:0]       grad_x_q, grad_y_q;
  logic [DEC_W-1:0]        decision_q, mul_q;
  logic [OUT_W-1:0]        point_x_q, point_y_q;
  logic                    last_q;

  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [DEC_W-1:0]        mul_p;
  logic [TX_W-1:0]         tx;
  logic [WALKY_W-1:0]      ym1, ym1_abs;
  logic [GRAD_W-1:0]       gx_inc, gy_dec;
  logic [WALKY_W-1:0]      y_dec;
  logic                    dec_neg, dec_pos, out_free;
  logic [DEC_W-1:0]        gx_ext, gy_ext, k_ext, term;
  logic [PT_W-1:0]         px_sum, py_sum;

  assign tx      = {walk_x_q, 1'b1};
  assign ym1     = walk_y_q - WALKY_W'(1);
  assign ym1_abs = ym1[WALKY_W-1] ? (~ym1 + WALKY_W'(1)) : ym1;

  // shared multiplier, product registered in mul_q
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      OP_MUL_AA:  begin mul_a = MUL_W'(axis_a_q);         mul_b = MUL_W'(axis_a_q); end
      OP_MUL_BB:  begin mul_a = MUL_W'(axis_b_q);         mul_b = MUL_W'(axis_b_q); end
      OP_MUL_AAB: begin mul_a = MUL_W'(aa_q);             mul_b = MUL_W'(axis_b_q); end
      OP_SW_TX:   begin mul_a = MUL_W'(tx);               mul_b = MUL_W'(tx);       end
      OP_SW_BTX:  begin mul_a = MUL_W'(bb_q);             mul_b = MUL_W'(mul_q[TXSQ_W-1:0]); end
      OP_SW_YSQ:  begin mul_a = MUL_W'(ym1_abs);          mul_b = MUL_W'(ym1_abs);  end
      OP_SW_AYY:  begin mul_a = MUL_W'(aa_q);             mul_b = MUL_W'(mul_q[TXSQ_W-1:0]); end
      OP_SW_ABB:  begin mul_a = MUL_W'(aa_q);             mul_b = MUL_W'(bb_q);     end
      default:    begin mul_a = '0;                       mul_b = '0;               end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign gx_inc  = grad_x_q + GRAD_W'({bb_q, 1'b0});
  assign gy_dec  = grad_y_q - GRAD_W'({aa_q, 1'b0});
  assign y_dec   = walk_y_q - WALKY_W'(1);
  assign dec_neg = decision_q[DEC_W-1];
  assign dec_pos = !dec_neg && (decision_q != '0);

  // decision increment, grads already advanced by the step
  assign gx_ext = {{(DEC_W-GRAD_W){grad_x_q[GRAD_W-1]}}, grad_x_q};
  assign gy_ext = {{(DEC_W-GRAD_W){grad_y_q[GRAD_W-1]}}, grad_y_q};
  assign k_ext  = second_q ? DEC_W'(aa_q) : DEC_W'(bb_q);

  always_comb begin
    if (!second_q) begin
      term = dec_neg ? (gx_ext + k_ext) : (gx_ext - gy_ext + k_ext);
    end else begin
      term = dec_pos ? (k_ext - gy_ext) : (gx_ext - gy_ext + k_ext);
    end
  end

  assign px_sum = {{(PT_W-COORD_BITS){origin_x_q[COORD_BITS-1]}}, origin_x_q}
                + PT_W'(walk_x_q);
  assign py_sum = {{(PT_W-COORD_BITS){origin_y_q[COORD_BITS-1]}}, origin_y_q}
                + {{(PT_W-WALKY_W){walk_y_q[WALKY_W-1]}}, walk_y_q};

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a step only issues once the previous point has left
      if (op_i == OP_STEP) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        OP_INIT: begin
          busy_q   <= 1'b1;
          second_q <= 1'b0;
        end
        OP_SW_END: second_q <= 1'b1;
        OP_STEP: begin
          if (second_q && y_dec[WALKY_W-1]) begin
            busy_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_p;
    case (op_i)
      OP_LOAD: begin
        axis_a_q   <= semi_axis_x_i;
        axis_b_q   <= semi_axis_y_i;
        origin_x_q <= center_x_i;
        origin_y_q <= center_y_i;
      end
      OP_MUL_BB:  aa_q <= mul_q[SQ_W-1:0];
      OP_MUL_AAB: bb_q <= mul_q[SQ_W-1:0];
      OP_INIT: begin
        walk_x_q   <= '0;
        walk_y_q   <= WALKY_W'(axis_b_q);
        grad_x_q   <= '0;
        grad_y_q   <= GRAD_W'({mul_q[AAB_W-1:0], 1'b0});
        decision_q <= DEC_W'({bb_q, 2'b00}) - DEC_W'({mul_q[AAB_W-1:0], 2'b00})
                    + DEC_W'(aa_q);
      end
      OP_SW_YSQ: decision_q <= mul_q;
      OP_SW_ABB: decision_q <= decision_q + {mul_q[DEC_W-3:0], 2'b00};
      OP_SW_END: decision_q <= decision_q - {mul_q[DEC_W-3:0], 2'b00};
      OP_STEP: begin
        point_x_q <= px_sum[OUT_W-1:0];
        point_y_q <= py_sum[OUT_W-1:0];
        last_q    <= second_q && y_dec[WALKY_W-1];
        if (!second_q) begin
          walk_x_q <= walk_x_q + WALKX_W'(1);
          grad_x_q <= gx_inc;
          if (!dec_neg) begin
            walk_y_q <= y_dec;
            grad_y_q <= gy_dec;
          end
        end else begin
          walk_y_q <= y_dec;
          grad_y_q <= gy_dec;
          if (!dec_pos) begin
            walk_x_q <= walk_x_q + WALKX_W'(1);
            grad_x_q <= gx_inc;
          end
        end
      end
      OP_DEC: decision_q <= decision_q + {term[DEC_W-3:0], 2'b00};
      default: ;
    endcase
  end

  assign status_o.busy     = busy_q;
  assign status_o.second   = second_q;
  assign status_o.grad_lt  = $signed(grad_x_q) < $signed(grad_y_q);
  assign status_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign point_x_o    = point_x_q;
  assign point_y_o    = point_y_q;
  assign last_point_o = last_q;

endmodule
`default_nettype wire

// File: hw/rtl/midpoint_ellipse_rasterizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Handshake               | Payload
// --------+-------------------------+-------------------------------------------
// in      | in_valid_i / in_stall_o | kind, semi_axis_x, semi_axis_y, center_x/y
// out     | out_valid_o/out_stall_i | point_x, point_y, last_point
//
// A start transaction passes through accept, three products on the shared multiplier
// and initialisation; an advance passes through accept, step (held while the result
// is stalled) and decision update, and the one advance where region 2 begins first runs
// the chain of products through the single registered multiplier.
// Reset clears the controller, the walk-active and region flags and the output valid.
// A stalled result holds the next step in place, and the input stalls until it is taken.
module midpoint_ellipse_rasterizer_top import mer_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic        [RADIUS_BITS-1:0] semi_axis_x_i,
  input  wire logic        [RADIUS_BITS-1:0] semi_axis_y_i,
  input  wire logic signed [COORD_BITS-1:0]  center_x_i,
  input  wire logic signed [COORD_BITS-1:0]  center_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed      [OUT_W-1:0]       point_x_o,
  output logic signed      [OUT_W-1:0]       point_y_o,
  output logic                               last_point_o
);

  // command from the sequencer, status back from the datapath
  dp_op_e     op;
  dp_status_t status;

  // sequencer: decodes the transaction kind and walks the multiplier schedule
  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .op_o       (op)
  );

  // datapath: walk registers, gradients, decision, multiplier and result register
  mer_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .semi_axis_x_i (semi_axis_x_i),
    .semi_axis_y_i (semi_axis_y_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .out_stall_i   (out_stall_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .last_point_o  (last_point_o)
  );

endmodule
`default_nettype wire

// File: hw/rtl/mer_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_ellipse_rasterizer_top_macros.svh"
module mer_checker import mer_pkg::*; (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          kind_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [OUT_W-1:0]       point_x_o,
  input wire logic signed [OUT_W-1:0]       point_y_o,
  input wire logic                          last_point_o
);

  `MER_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `MER_ASSERT_MSG(a_out_stable, out_valid_o && out_stall_i |=> $stable(point_x_o) && $stable(point_y_o) && $stable(last_point_o), "stalled result changed")
  `MER_ASSERT_MSG(a_start_busy, in_valid_i && !in_stall_o && kind_i == KIND_START |=> in_stall_o, "start transaction not followed by set-up")
  `MER_ASSERT(a_result_from_step, $rose(out_valid_o) |-> $past(in_stall_o))

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker u_mer_checker (.*);
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mer_pkg::*;

  // Run shape: live transactions in the random part, watchdog, tail after the last point,
  // and the one long hold-off on the result side.
  localparam int unsigned ITEM_TARGET  = 400;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AT_ITEM = 60;

  localparam logic [RADIUS_BITS-1:0] AXIS_MAX  = '1;
  localparam logic [COORD_BITS-1:0]  COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [COORD_BITS-1:0]  COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             last;
  } plot_point_t;

  // Tracks the quadrant walk of the block and keeps the points it still owes.
  // All walk arithmetic is 64-bit and wraps, so every value stays exact within
  // the package sizes.
  class ellipse_tracker;
    bit          active;
    bit          on_lower_arc;
    bit [63:0]   pos_x, pos_y, slope_x, slope_y, err4;
    bit [63:0]   semi_a, semi_b, centre_x, centre_y;
    plot_point_t due_points[$];
    int unsigned mismatches;

    // Apply one accepted input transaction; return 1 unless the block ignores it.
    function bit absorb_command(input logic kind_in,
                                input logic [RADIUS_BITS-1:0] a,
                                input logic [RADIUS_BITS-1:0] b,
                                input logic [COORD_BITS-1:0] h,
                                input logic [COORD_BITS-1:0] v);
      bit [63:0]   aa, bb, tx, ym1, px, py;
      plot_point_t pt;
      if (kind_in == KIND_START) begin
        semi_a   = 64'(a);
        semi_b   = 64'(b);
        centre_x = {{(64-COORD_BITS){h[COORD_BITS-1]}}, h};
        centre_y = {{(64-COORD_BITS){v[COORD_BITS-1]}}, v};
        aa = semi_a * semi_a;
        bb = semi_b * semi_b;
        pos_x   = '0;
        pos_y   = semi_b;
        slope_x = '0;
        slope_y = 64'd2 * aa * semi_b;
        err4    = 64'd4 * bb - 64'd4 * aa * semi_b + aa;
        on_lower_arc = 1'b0;
        active       = 1'b1;
        return 1'b1;
      end
      if (!active) return 1'b0;

      aa = semi_a * semi_a;
      bb = semi_b * semi_b;
      // Cross into the steep part with a freshly computed decision value
      if (!on_lower_arc && !(slope_x < slope_y)) begin
        on_lower_arc = 1'b1;
        tx  = 64'd2 * pos_x + 64'd1;
        ym1 = pos_y - 64'd1;
        err4 = bb * tx * tx + 64'd4 * aa * ym1 * ym1 - 64'd4 * aa * bb;
      end

      px = pos_x + centre_x;
      py = pos_y + centre_y;
      pt.last = 1'b0;
      if (!on_lower_arc) begin
        pos_x   += 64'd1;
        slope_x += 64'd2 * bb;
        if (err4[63]) begin
          err4 += 64'd4 * (slope_x + bb);
        end else begin
          pos_y   -= 64'd1;
          slope_y -= 64'd2 * aa;
          err4    += 64'd4 * (slope_x - slope_y + bb);
        end
      end else begin
        pos_y   -= 64'd1;
        slope_y -= 64'd2 * aa;
        if (!err4[63] && err4 != 64'd0) begin
          err4 += 64'd4 * (aa - slope_y);
        end else begin
          pos_x   += 64'd1;
          slope_x += 64'd2 * bb;
          err4    += 64'd4 * (slope_x - slope_y + aa);
        end
        // y has dropped below the axis: the quadrant is complete
        if (pos_y[63]) begin
          active  = 1'b0;
          pt.last = 1'b1;
        end
      end
      pt.x = px[OUT_W-1:0];
      pt.y = py[OUT_W-1:0];
      due_points.push_back(pt);
      return 1'b1;
    endfunction

    // Match one accepted result transaction against the oldest owed point.
    function void compare_point(input logic [OUT_W-1:0] x, input logic [OUT_W-1:0] y,
                                input logic last);
      plot_point_t pt;
      if (due_points.size() == 0) begin
        $error("unexpected point (%0d, %0d), last_point %0b", $signed(x), $signed(y), last);
        mismatches++;
        return;
      end
      pt = due_points.pop_front();
      if (x !== pt.x) begin
        $error("point_x: expected %0d, actual %0d", $signed(pt.x), $signed(x));
        mismatches++;
      end
      if (y !== pt.y) begin
        $error("point_y: expected %0d, actual %0d", $signed(pt.y), $signed(y));
        mismatches++;
      end
      if (last !== pt.last) begin
        $error("last_point: expected %0b, actual %0b", pt.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          kind = KIND_START;
  logic        [RADIUS_BITS-1:0] semi_a_in = '0;
  logic        [RADIUS_BITS-1:0] semi_b_in = '0;
  logic signed [COORD_BITS-1:0]  centre_x_in = '0;
  logic signed [COORD_BITS-1:0]  centre_y_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [OUT_W-1:0]       point_x;
  logic signed [OUT_W-1:0]       point_y;
  logic                          last_point;

  ellipse_tracker tracker;
  int unsigned    live_items = 0;
  int unsigned    sender_idle_pct = 23;
  int unsigned    receiver_idle_pct = 52;
  bit             hold_request = 1'b0;
  bit             hold_taken = 1'b0;
  int unsigned    hold_left = 0;
  int unsigned    cycle_count = 0;

  midpoint_ellipse_rasterizer_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .semi_axis_x_i (semi_a_in),
    .semi_axis_y_i (semi_b_in),
    .center_x_i    (centre_x_in),
    .center_y_i    (centre_y_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .point_x_o     (point_x),
    .point_y_o     (point_y),
    .last_point_o  (last_point)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one input transaction after a random idle gap, hold it until taken,
  // then advance the tracker and the idling phase.
  task automatic drive_item(input logic k_in,
                            input logic [RADIUS_BITS-1:0] a,
                            input logic [RADIUS_BITS-1:0] b,
                            input logic [COORD_BITS-1:0] h,
                            input logic [COORD_BITS-1:0] v);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k_in;
    semi_a_in   <= a;
    semi_b_in   <= b;
    centre_x_in <= h;
    centre_y_in <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (tracker.absorb_command(k_in, a, b, h, v)) live_items++;
    // Ask the result side for its long hold-off once, early in the first phase
    if (live_items >= HOLD_AT_ITEM) hold_request = 1'b1;
    // Swap the idling rates after a third, drop idling altogether after two thirds
    if (live_items >= 2 * ITEM_TARGET / 3) begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end else if (live_items >= ITEM_TARGET / 3) begin
      sender_idle_pct   = 52;
      receiver_idle_pct = 23;
    end
  endtask

  // Advance with junk in the start-only fields, which the block must disregard.
  task automatic step_point();
    drive_item(KIND_ADVANCE, RADIUS_BITS'($urandom), RADIUS_BITS'($urandom),
               COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  // Advance until the quadrant is done, then send some advances into the idle block.
  task automatic finish_walk(input int unsigned spare);
    while (tracker.active) step_point();
    repeat (spare) step_point();
  endtask

  // One random ellipse: mostly small and walked to the end, a few large or
  // cut short by the next start.
  task automatic random_ellipse();
    int unsigned            pick;
    logic [RADIUS_BITS-1:0] a;
    logic [RADIUS_BITS-1:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      a = RADIUS_BITS'($urandom);
      b = RADIUS_BITS'($urandom);
    end else if (pick < 30) begin
      a = RADIUS_BITS'($urandom_range(0, 63));
      b = RADIUS_BITS'($urandom_range(0, 63));
    end else begin
      a = RADIUS_BITS'($urandom_range(0, 12));
      b = RADIUS_BITS'($urandom_range(0, 12));
    end
    drive_item(KIND_START, a, b, COORD_BITS'($urandom), COORD_BITS'($urandom));
    if (pick < 8 || $urandom_range(0, 9) == 0)
      repeat ($urandom_range(0, 40)) step_point();
    else
      finish_walk(($urandom_range(0, 3) == 0) ? 1 : 0);
  endtask

  // Result side: take points, pick the next stall, and serve the long hold-off
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.compare_point(point_x, point_y, last_point);
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Advance before any start: drop it
    step_point();
    // Both axes zero: a single point at the centre, flagged last
    drive_item(KIND_START, '0, '0, COORD_MIN, COORD_MAX);
    finish_walk(1);
    // Zero horizontal axis: straight down from b to 0
    drive_item(KIND_START, '0, RADIUS_BITS'(3), COORD_MAX, COORD_MIN);
    finish_walk(0);
    // Zero vertical axis: one point only
    drive_item(KIND_START, RADIUS_BITS'(3), '0, '0, '0);
    finish_walk(0);
    // Largest axes at the top corner, restarted mid-walk
    drive_item(KIND_START, AXIS_MAX, AXIS_MAX, COORD_MAX, COORD_MAX);
    repeat (3) step_point();
    drive_item(KIND_START, RADIUS_BITS'(1), RADIUS_BITS'(1), '1, '1);
    finish_walk(0);
    drive_item(KIND_START, AXIS_MAX, RADIUS_BITS'(1), COORD_MIN, COORD_MIN);
    repeat (3) step_point();
    drive_item(KIND_START, RADIUS_BITS'(2), RADIUS_BITS'(5), COORD_BITS'(100),
               COORD_BITS'(-100));
    finish_walk(1);

    while (live_items < ITEM_TARGET) random_ellipse();

    // One full quadrant of a mid-sized ellipse, through the region switch
    // with wide products
    drive_item(KIND_START, RADIUS_BITS'($urandom_range(320, 400)),
               RADIUS_BITS'($urandom_range(320, 400)), COORD_MAX, COORD_BITS'($urandom));
    finish_walk(1);

    in_valid <= 1'b0;
    while (tracker.due_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
